// ===== rtl/core/nuws_pkg.sv =====
// ----------------------------------------------------------------------------
// nuws_pkg
// Shared constants and types for the nearest unvisited waypoint selector.
// ----------------------------------------------------------------------------
package nuws_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // configuration port
    localparam int               APB_AW             = 3;
    localparam logic [APB_AW-1:0] ADDR_ARRIVAL_RANGE = 3'd0;
    localparam logic [15:0]      ARRIVAL_RANGE_RST  = 16'd160;

    localparam logic [6:0] REM_MAX = 7'd127;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

endpackage

// ===== rtl/core/nearest_unvisited_waypoint_selector_core.sv =====
// ----------------------------------------------------------------------------
// nearest_unvisited_waypoint_selector_core
// Greedy nearest-neighbour waypoint selection over a loaded waypoint table.
// ----------------------------------------------------------------------------
// One item is processed at a time and each gives one result transaction.
// Append, clear and unused commands go from acceptance straight to the
// result state; a position update that does not reach the target makes one
// pass through the 3-stage distance pipe. An update that arrives walks every
// filled slot of the waypoint memory, one read a cycle through its single
// read port and then the distance pipe. The next item is taken while a
// result still waits on m_tready. Entries past the fill count are never
// read, so the table needs no clearing pass after reset or a clear command.
module nearest_unvisited_waypoint_selector_core #(
    parameter int TABLE_DEPTH = nuws_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH = nuws_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // configuration
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [nuws_pkg::APB_AW-1:0]                paddr,
    input  logic [31:0]                                pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready,
    // input stream
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // pos_x, pos_y, zero pad
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]         s_tdata,
    // command
    input  logic [1:0]                                 s_tuser,
    // result stream
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // target_x, target_y, arrived, done_res, remaining[6:0], status, zero pad
    output logic [((2*COORD_WIDTH+17)/8)*8-1:0]        m_tdata
);
    import nuws_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNTW  = $clog2(TABLE_DEPTH + 1);
    localparam int EW    = 2*CW + 1;
    localparam int DW    = (2*CW + 1 > 64) ? 64 : 2*CW + 1;
    localparam int SUMW  = (2*CW + 1 > 64) ? 2*CW + 1 : 64;
    localparam int CMPW  = (DW > 32) ? DW : 32;
    localparam int RCW   = (CNTW > 7) ? CNTW : 7;
    localparam int MDW   = ((2*CW + 17)/8)*8;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [15:0]         arrival_range_reg;
    logic [31:0]         range_sq_reg;
    logic [CW-1:0]       tgt_x_reg, tgt_y_reg;
    logic                finished_reg;
    logic [CNTW-1:0]     fill_reg;
    logic [CNTW-1:0]     count_reg;
    logic [CW-1:0]       pos_x_reg, pos_y_reg;
    logic                arrived_reg, status_reg;

    logic [CNTW-1:0]     scan_reg;
    logic                rd_vld_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic [EW-1:0]       rd_data_reg;

    logic                p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [CW-1:0]       p1_abs_x_reg, p1_abs_y_reg;
    logic [2*CW-1:0]     p2_sq_x_reg, p2_sq_y_reg;
    logic [DW-1:0]       p3_dist_reg;
    logic [CW-1:0]       p1_bx_reg, p1_by_reg, p2_bx_reg, p2_by_reg, p3_bx_reg, p3_by_reg;

    logic                best_found_reg;
    logic [DW-1:0]       best_dist_reg;
    logic [CW-1:0]       best_x_reg, best_y_reg;

    logic                m_tvalid_reg;
    logic [MDW-1:0]      m_tdata_reg;

    logic [EW-1:0]       mem [TABLE_DEPTH];

    // ------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------
    logic                accept;
    cmd_t                cmd;
    logic [CW-1:0]       in_x, in_y;
    logic                table_full;

    logic [CW-1:0]       rd_x, rd_y;
    logic                rd_live, rd_match;

    logic                op_vld;
    logic [CW-1:0]       op_ax, op_ay, op_bx, op_by;
    logic [CW:0]         diff_x, diff_y, neg_x, neg_y;
    logic [CW-1:0]       abs_x, abs_y;
    logic [2*CW-1:0]     sq_x, sq_y;
    logic [SUMW-1:0]     sum_e;
    logic [DW-1:0]       dist_c;
    logic                near;
    logic                better;

    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                scan_end;
    logic                out_free;
    logic [RCW-1:0]      count_ext;
    logic [6:0]          rem;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_ARRIVAL_RANGE) ? {16'd0, arrival_range_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign in_x     = s_tdata[CW-1:0];
    assign in_y     = s_tdata[2*CW-1:CW];
    assign table_full = (fill_reg == CNTW'(TABLE_DEPTH));

    assign rd_x     = rd_data_reg[CW-1:0];
    assign rd_y     = rd_data_reg[2*CW-1:CW];
    assign rd_live  = rd_data_reg[2*CW];
    assign rd_match = rd_live && (rd_x == tgt_x_reg) && (rd_y == tgt_y_reg);

    // distance pipe operand select: arrival check from IDLE, candidates during scan
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            op_vld = accept && (cmd == CMD_UPDATE) && !finished_reg;
            op_ax  = in_x;
            op_ay  = in_y;
            op_bx  = tgt_x_reg;
            op_by  = tgt_y_reg;
        end
        else
        begin
            op_vld = (state_reg == ST_SCAN) && rd_vld_reg && rd_live && !rd_match;
            op_ax  = pos_x_reg;
            op_ay  = pos_y_reg;
            op_bx  = rd_x;
            op_by  = rd_y;
        end
    end

    assign diff_x = {op_ax[CW-1], op_ax} - {op_bx[CW-1], op_bx};
    assign diff_y = {op_ay[CW-1], op_ay} - {op_by[CW-1], op_by};
    assign neg_x  = (CW+1)'(0) - diff_x;
    assign neg_y  = (CW+1)'(0) - diff_y;
    // |a - b| never exceeds 2^CW - 1
    assign abs_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
    assign abs_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

    assign sq_x   = (2*CW)'(p1_abs_x_reg) * (2*CW)'(p1_abs_x_reg);
    assign sq_y   = (2*CW)'(p1_abs_y_reg) * (2*CW)'(p1_abs_y_reg);

    // sum saturates at 64 bits of ones
    assign sum_e  = SUMW'(p2_sq_x_reg) + SUMW'(p2_sq_y_reg);
    assign dist_c = (sum_e > SUMW'(64'hFFFF_FFFF_FFFF_FFFF)) ? {DW{1'b1}} : DW'(sum_e);

    assign near   = CMPW'(p3_dist_reg) < CMPW'(range_sq_reg);
    assign better = !best_found_reg || (p3_dist_reg < best_dist_reg);

    assign rd_en   = (state_reg == ST_SCAN) && (scan_reg < fill_reg);
    assign rd_addr = scan_reg[IW-1:0];

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            wr_en   = accept && (cmd == CMD_APPEND) && !table_full;
            wr_addr = fill_reg[IW-1:0];
            wr_data = {1'b1, in_y, in_x};
        end
        else
        begin
            wr_en   = (state_reg == ST_SCAN) && rd_vld_reg && rd_match;
            wr_addr = rd_idx_reg;
            wr_data = {1'b0, rd_y, rd_x};
        end
    end

    assign scan_end = (state_reg == ST_SCAN) && (scan_reg == fill_reg) && !rd_vld_reg
                      && !p1_vld_reg && !p2_vld_reg && !p3_vld_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign count_ext = RCW'(count_reg);
    assign rem       = (count_ext > RCW'(REM_MAX)) ? REM_MAX : count_ext[6:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // State sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == CMD_UPDATE) && !finished_reg)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_CHECK:
            begin
                if (p3_vld_reg)
                    state_next = near ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Waypoint memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            arrival_range_reg <= ARRIVAL_RANGE_RST;
            range_sq_reg      <= 32'(ARRIVAL_RANGE_RST) * 32'(ARRIVAL_RANGE_RST);
            tgt_x_reg         <= '0;
            tgt_y_reg         <= '0;
            finished_reg      <= 1'b0;
            fill_reg          <= '0;
            count_reg         <= '0;
            arrived_reg       <= 1'b0;
            status_reg        <= 1'b0;
            scan_reg          <= '0;
            rd_vld_reg        <= 1'b0;
            p1_vld_reg        <= 1'b0;
            p2_vld_reg        <= 1'b0;
            p3_vld_reg        <= 1'b0;
            best_found_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            range_sq_reg <= 32'(arrival_range_reg) * 32'(arrival_range_reg);
            if (psel && penable && pwrite && pready && (paddr == ADDR_ARRIVAL_RANGE))
                arrival_range_reg <= pwdata[15:0];

            rd_vld_reg <= rd_en;
            p1_vld_reg <= op_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;

            if ((state_reg == ST_RESULT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        arrived_reg <= 1'b0;
                        status_reg  <= (cmd == CMD_APPEND) && table_full;
                        case (cmd)
                            CMD_APPEND:
                            begin
                                if (!table_full)
                                begin
                                    fill_reg  <= fill_reg + CNTW'(1);
                                    count_reg <= count_reg + CNTW'(1);
                                end
                            end
                            CMD_CLEAR:
                            begin
                                fill_reg     <= '0;
                                count_reg    <= '0;
                                finished_reg <= 1'b0;
                                tgt_x_reg    <= '0;
                                tgt_y_reg    <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    if (p3_vld_reg && near)
                    begin
                        arrived_reg    <= 1'b1;
                        scan_reg       <= '0;
                        best_found_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                        scan_reg <= scan_reg + CNTW'(1);
                    if (wr_en)
                        count_reg <= count_reg - CNTW'(1);
                    if (p3_vld_reg && better)
                        best_found_reg <= 1'b1;
                    if (scan_end)
                    begin
                        if (best_found_reg)
                        begin
                            tgt_x_reg <= best_x_reg;
                            tgt_y_reg <= best_y_reg;
                        end
                        else
                            finished_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_x_reg <= in_x;
            pos_y_reg <= in_y;
        end

        rd_idx_reg   <= rd_addr;

        p1_abs_x_reg <= abs_x;
        p1_abs_y_reg <= abs_y;
        p1_bx_reg    <= op_bx;
        p1_by_reg    <= op_by;

        p2_sq_x_reg  <= sq_x;
        p2_sq_y_reg  <= sq_y;
        p2_bx_reg    <= p1_bx_reg;
        p2_by_reg    <= p1_by_reg;

        p3_dist_reg  <= dist_c;
        p3_bx_reg    <= p2_bx_reg;
        p3_by_reg    <= p2_by_reg;

        // strict compare keeps the lowest index on a tie
        if ((state_reg == ST_SCAN) && p3_vld_reg && better)
        begin
            best_dist_reg <= p3_dist_reg;
            best_x_reg    <= p3_bx_reg;
            best_y_reg    <= p3_by_reg;
        end

        if ((state_reg == ST_RESULT) && out_free)
            m_tdata_reg <= MDW'({status_reg, rem, finished_reg, arrived_reg,
                                 tgt_y_reg, tgt_x_reg});
    end

endmodule

// ===== tb/sv/nuws_checker.sv =====
// ----------------------------------------------------------------------------
// nuws_checker
// Watches the configuration port and both streams of the waypoint selector.
// It keeps its own copy of the table, target and arrival range, works out the
// result of every accepted command and compares it with the result stream.
// ----------------------------------------------------------------------------
module nuws_checker #(
    parameter int CW    = nuws_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = nuws_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nuws_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    input  logic [31:0]                        prdata,
    input  logic                               pready,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // pos_x, pos_y, zero pad
    input  logic [((2*CW+7)/8)*8-1:0]          s_tdata,
    // command
    input  logic [1:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // target_x, target_y, arrived, done_res, remaining[6:0], status, zero pad
    input  logic [((2*CW+17)/8)*8-1:0]         m_tdata,
    output int                                 mismatch_count,
    output int                                 outstanding,
    output logic signed [CW-1:0]               cur_tx,
    output logic signed [CW-1:0]               cur_ty,
    output logic                               tour_done
);
    timeunit 1ns;
    timeprecision 1ps;

    import nuws_pkg::*;

    localparam int MW = ((2*CW+17)/8)*8;

    typedef struct packed {
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic                 arrived;
        logic                 done_flag;
        logic [6:0]           remaining;
        logic                 status;
    } waypoint_report_t;

    waypoint_report_t     target_reports_q[$];

    logic signed [CW-1:0] wp_x [DEPTH];
    logic signed [CW-1:0] wp_y [DEPTH];
    logic [DEPTH-1:0]     wp_live;
    int                   fill;
    logic signed [CW-1:0] tgt_x;
    logic signed [CW-1:0] tgt_y;
    logic                 finished;
    logic [15:0]          arr_range;
    int                   errors;

    // exact squared distance, saturating at 64 bits of ones for wide coordinates
    function automatic logic [63:0] sq_dist(input logic signed [CW-1:0] ax,
                                            input logic signed [CW-1:0] ay,
                                            input logic signed [CW-1:0] bx,
                                            input logic signed [CW-1:0] by);
        longint      dx;
        longint      dy;
        logic [64:0] s;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        s = {1'b0, 64'(dx * dx)} + {1'b0, 64'(dy * dy)};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    task automatic apply_waypoint_cmd(input logic [1:0] cmd,
                                      input logic signed [CW-1:0] px,
                                      input logic signed [CW-1:0] py);
        waypoint_report_t r;
        logic             found;
        logic [63:0]      best;
        logic [63:0]      d;
        logic [63:0]      range_sq;
        int               best_i;
        int               live_n;
        r = '0;
        found = 1'b0;
        best = '0;
        best_i = 0;
        range_sq = {48'b0, arr_range} * {48'b0, arr_range};
        case (cmd)
            CMD_APPEND:
            begin
                if (fill < DEPTH)
                begin
                    wp_x[fill] = px;
                    wp_y[fill] = py;
                    wp_live[fill] = 1'b1;
                    fill++;
                end
                else
                    r.status = 1'b1;
            end
            CMD_UPDATE:
            begin
                if (!finished && sq_dist(px, py, tgt_x, tgt_y) < range_sq)
                begin
                    r.arrived = 1'b1;
                    // drop every copy of the target, then pick the nearest survivor
                    for (int i = 0; i < DEPTH; i++)
                        if (wp_live[i] && wp_x[i] == tgt_x && wp_y[i] == tgt_y)
                            wp_live[i] = 1'b0;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (wp_live[i])
                        begin
                            d = sq_dist(px, py, wp_x[i], wp_y[i]);
                            if (!found || d < best)
                            begin
                                found = 1'b1;
                                best = d;
                                best_i = i;
                            end
                        end
                    end
                    if (found)
                    begin
                        tgt_x = wp_x[best_i];
                        tgt_y = wp_y[best_i];
                    end
                    else
                        finished = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                wp_live = '0;
                fill = 0;
                finished = 1'b0;
                tgt_x = '0;
                tgt_y = '0;
            end
            default: ;
        endcase
        live_n = $countones(wp_live);
        r.tx = tgt_x;
        r.ty = tgt_y;
        r.done_flag = finished;
        r.remaining = (live_n > int'(REM_MAX)) ? REM_MAX : 7'(live_n);
        target_reports_q = {target_reports_q, r};
    endtask

    task automatic check_report(input logic [MW-1:0] word);
        waypoint_report_t got;
        waypoint_report_t want;
        got.tx        = word[CW-1:0];
        got.ty        = word[2*CW-1:CW];
        got.arrived   = word[2*CW];
        got.done_flag = word[2*CW+1];
        got.remaining = word[2*CW+8:2*CW+2];
        got.status    = word[2*CW+9];
        if (target_reports_q.size() == 0)
        begin
            if (errors < 10)
                $display("%0t: result transaction with nothing expected: %h", $realtime, word);
            errors++;
        end
        else
        begin
            want = target_reports_q.pop_front();
            if (got !== want)
            begin
                if (errors < 10)
                begin
                    $write("%0t: result mismatch: expected tx=%0d ty=%0d arr=%0b ",
                           $realtime, want.tx, want.ty, want.arrived);
                    $write("done=%0b rem=%0d st=%0b, ",
                           want.done_flag, want.remaining, want.status);
                    $write("got tx=%0d ty=%0d arr=%0b ", got.tx, got.ty, got.arrived);
                    $display("done=%0b rem=%0d st=%0b",
                             got.done_flag, got.remaining, got.status);
                end
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reports_q.delete();
            wp_live = '0;
            fill = 0;
            tgt_x = '0;
            tgt_y = '0;
            finished = 1'b0;
            arr_range = ARRIVAL_RANGE_RST;
            errors = 0;
        end
        else
        begin
            // results leave before the transaction accepted on the same edge
            if (m_tvalid && m_tready)
                check_report(m_tdata);
            if (s_tvalid && s_tready)
                apply_waypoint_cmd(s_tuser, s_tdata[CW-1:0], s_tdata[2*CW-1:CW]);
            if (psel && penable && pready && paddr == ADDR_ARRIVAL_RANGE)
            begin
                if (pwrite)
                    arr_range = pwdata[15:0];
                else if (prdata !== {16'b0, arr_range})
                begin
                    if (errors < 10)
                        $display("%0t: register read mismatch: expected %0d, got %0d",
                                 $realtime, arr_range, prdata);
                    errors++;
                end
            end
        end
        mismatch_count <= errors;
        outstanding    <= target_reports_q.size();
        cur_tx         <= tgt_x;
        cur_ty         <= tgt_y;
        tour_done      <= finished;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nearest unvisited waypoint selector. A short
// directed tour walks the corner cases, then random tours run under several
// arrival ranges and handshake idling patterns; nuws_checker does the checking.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nuws_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int SW          = ((2*CW+7)/8)*8;
    localparam int MW          = ((2*CW+17)/8)*8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 185;
    localparam int NUM_PHASES  = 6;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SW-1:0]        s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MW-1:0]        m_tdata;

    int                   mismatch_count;
    int                   outstanding;
    logic signed [CW-1:0] cur_tx;
    logic signed [CW-1:0] cur_ty;
    logic                 tour_done;

    int                   idle_pct    = 0;
    int                   stall_pct   = 0;
    int                   items_sent  = 0;
    int                   cycle_count = 0;
    logic [15:0]          cur_range   = ARRIVAL_RANGE_RST;

    nearest_unvisited_waypoint_selector_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nuws_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .cur_tx         (cur_tx),
        .cur_ty         (cur_ty),
        .tour_done      (tour_done)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_unvisited_waypoint_selector_core test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= SW'({y, x});
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is back, then a tail for the block to go quiet
    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input logic cluster);
        // clustered points on a coarse grid give duplicates and distance ties
        if (cluster)
            return CW'(16 * (int'($urandom_range(0, 6)) - 3));
        return CW'($urandom);
    endfunction

    function automatic logic signed [CW-1:0] near(input logic signed [CW-1:0] c,
                                                  input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > (1 << (CW-1)) - 1)
            v = (1 << (CW-1)) - 1;
        if (v < -(1 << (CW-1)))
            v = -(1 << (CW-1));
        return CW'(v);
    endfunction

    // load a set of waypoints, then chase the current target with some noise
    task automatic run_tour(input int n_pts);
        int   k;
        int   pick;
        int   spread;
        logic cluster;
        cluster = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 9) != 0)
            send_item(CMD_CLEAR, rand_coord(1'b0), rand_coord(1'b0));
        for (k = 0; k < n_pts; k++)
            send_item(CMD_APPEND, rand_coord(cluster), rand_coord(cluster));
        for (k = 0; k < 2 * n_pts + 4; k++) begin
            if (tour_done && $urandom_range(0, 3) != 0)
                break;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 80)
                spread = int'(cur_range) * 7 / 10;
            else
                spread = int'(cur_range) * 2 + 16;
            if (pick < 72)
                send_item(CMD_UPDATE, near(cur_tx, spread), near(cur_ty, spread));
            else if (pick < 84)
                send_item(CMD_UPDATE, rand_coord(1'b0), rand_coord(1'b0));
            else if (pick < 91)
                send_item(CMD_APPEND, rand_coord(cluster), rand_coord(cluster));
            else if (pick < 96)
                send_item(CMD_UNUSED, rand_coord(1'b0), rand_coord(1'b0));
            else
                send_item(CMD_CLEAR, rand_coord(1'b0), rand_coord(1'b0));
        end
    endtask

    initial
    begin
        int   p;
        int   n;
        int   phase_start;
        logic first_tour;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, ADDR_ARRIVAL_RANGE, 32'd0);

        // directed tour, default arrival range of 160
        send_item(CMD_UPDATE, 16'sd0, 16'sd0);          // arrival with an empty table
        send_item(CMD_UPDATE, 16'sd5, 16'sd5);          // ignored while finished
        send_item(CMD_APPEND, 16'sd100, 16'sd100);      // stored, finished stays set
        send_item(CMD_UNUSED, 16'sh7FFF, 16'sh8000);
        send_item(CMD_CLEAR, -16'sd1, -16'sd1);
        send_item(CMD_APPEND, 16'sh8000, 16'sh8000);
        send_item(CMD_APPEND, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_APPEND, 16'sd0, 16'sd0);
        send_item(CMD_APPEND, 16'sd0, 16'sd0);          // duplicate of the origin
        send_item(CMD_APPEND, 16'sd40, 16'sd0);
        send_item(CMD_APPEND, -16'sd40, 16'sd0);        // ties with the one before
        send_item(CMD_UPDATE, 16'sh7FFF, 16'sh7FFF);    // far away, target kept
        send_item(CMD_UPDATE, 16'sd0, 16'sd0);          // both origin copies go
        send_item(CMD_UPDATE, 16'sd140, 16'sd0);
        send_item(CMD_UPDATE, -16'sd40, 16'sd160);      // exactly on the radius
        send_item(CMD_UPDATE, -16'sd40, 16'sd159);
        send_item(CMD_UPDATE, 16'sh7FFF, 16'sh7FFF);
        send_item(CMD_UPDATE, 16'sh8000, 16'sh8000);    // last one, tour finishes
        send_item(CMD_UPDATE, 16'sh8000, 16'sh8000);
        send_item(CMD_CLEAR, 16'sd0, 16'sd0);

        for (p = 0; p < NUM_PHASES; p++) begin
            settle(16);
            case (p)
                0:       cur_range = 16'hFFFF;
                1:       cur_range = 16'd0;
                2:       cur_range = 16'($urandom_range(2, 4000));
                3:       cur_range = ARRIVAL_RANGE_RST;
                4:       cur_range = 16'd1;
                default: cur_range = 16'($urandom_range(4001, 65534));
            endcase
            apb_access(1'b1, ADDR_ARRIVAL_RANGE, {16'($urandom), cur_range});
            apb_access(1'b0, ADDR_ARRIVAL_RANGE, 32'd0);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            phase_start = items_sent;
            first_tour = 1'b1;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                // some phases open with an overfilled table
                if (first_tour && p % 3 == 0)
                    n = $urandom_range(65, 68);
                else if ($urandom_range(0, 99) < 85)
                    n = $urandom_range(1, 10);
                else if ($urandom_range(0, 99) < 70)
                    n = $urandom_range(11, 40);
                else
                    n = $urandom_range(60, 70);
                first_tour = 1'b0;
                run_tour(n);
            end
        end

        settle(80);
        if (mismatch_count == 0 && outstanding == 0)
            $display("nearest_unvisited_waypoint_selector_core test passed");
        else
            $display("nearest_unvisited_waypoint_selector_core test failed");
        $finish;
    end

endmodule
